[sv/lfcs_pkg.sv]
package lfcs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int INDEX_W    = 16;
  localparam int HOLD_CNT_W = 6;

  localparam logic [7:0]         NEWLINE   = 8'd10;
  localparam logic [INDEX_W-1:0] INDEX_MAX = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_MODE   = 3'd0,
    CFG_DELIMITER    = 3'd1,
    CFG_COMPLEMENT   = 3'd2,
    CFG_SKIP_UNDELIM = 3'd3,
    CFG_A_FIRST      = 3'd4,
    CFG_A_FINAL      = 3'd5,
    CFG_B_FIRST      = 3'd6,
    CFG_B_FINAL      = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    BK_IDLE,
    BK_DRAIN
  } back_state_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } lfcs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_done;
    logic       held_overflow;
  } lfcs_out_t;

  typedef struct packed {
    logic               field_mode;
    logic [7:0]         delimiter;
    logic               complement;
    logic               skip_undelimited;
    logic [INDEX_W-1:0] range_a_first;
    logic [INDEX_W-1:0] range_a_final;
    logic [INDEX_W-1:0] range_b_first;
    logic [INDEX_W-1:0] range_b_final;
  } lfcs_cfg_t;

  // at most one command per accepted item: optional hold drain, then optional byte
  typedef struct packed {
    logic                  drain;
    logic [HOLD_CNT_W-1:0] count;
    logic                  emit;
    logic [7:0]            data;
    logic                  done;
    logic                  ovf;
  } lfcs_cmd_t;

  typedef struct packed {
    logic                  en;
    logic [HOLD_CNT_W-1:0] addr;
    logic [7:0]            data;
  } lfcs_hold_wr_t;

  localparam int CMD_W = $bits(lfcs_cmd_t);
  localparam int OUT_W = $bits(lfcs_out_t);

endpackage

[sv/lfcs_fifo.sv]
module lfcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic [CW-1:0]    count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[sv/lfcs_front.sv]
module lfcs_front
  import lfcs_pkg::*;
#(
  parameter int HOLD_DEPTH = 63,
  localparam int CW = $clog2(HOLD_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lfcs_cfg_t     cfg_i,
  input  logic          push_i,
  input  lfcs_in_t      item_i,
  output logic          full_o,
  input  logic          cmd_full_i,
  output logic          cmd_push_o,
  output lfcs_cmd_t     cmd_o,
  output lfcs_hold_wr_t hold_wr_o,
  input  logic          drain_done_i
);

  logic [INDEX_W-1:0] idx_q, idx_d, idx_inc;
  logic               saw_sep_q, saw_sep_d;
  logic               wrote_q, wrote_d;
  logic               sel_q, sel_d;
  logic [CW-1:0]      hcnt_q, hcnt_d;
  logic               ovf_q, ovf_d;
  logic               pending_q, pending_d;
  logic               accept, sel_cur, sel_next, is_cont;

  function automatic logic is_selected(input lfcs_cfg_t c, input logic [INDEX_W-1:0] i);
    logic a, b;
    a = (i >= c.range_a_first) && (i <= c.range_a_final);
    b = (i >= c.range_b_first) && (i <= c.range_b_final);
    return (a || b) ^ c.complement;
  endfunction

  assign full_o   = cmd_full_i || pending_q;
  assign accept   = push_i && !full_o;
  assign idx_inc  = (idx_q == INDEX_MAX) ? idx_q : idx_q + INDEX_W'(1);
  assign sel_cur  = is_selected(cfg_i, idx_q);
  assign sel_next = is_selected(cfg_i, idx_inc);
  assign is_cont  = (item_i.text_byte[7:6] == 2'b10) && saw_sep_q;

  always_comb begin
    idx_d      = idx_q;
    saw_sep_d  = saw_sep_q;
    wrote_d    = wrote_q;
    sel_d      = sel_q;
    hcnt_d     = hcnt_q;
    ovf_d      = ovf_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.ovf  = ovf_q;
    hold_wr_o  = '0;
    if (accept) begin
      if (item_i.line_end) begin
        if (!(cfg_i.field_mode && !saw_sep_q && cfg_i.skip_undelimited)) begin
          cmd_push_o = 1'b1;
          cmd_o.emit = 1'b1;
          cmd_o.data = NEWLINE;
          cmd_o.done = 1'b1;
          if (cfg_i.field_mode && !saw_sep_q && (hcnt_q != '0)) begin
            cmd_o.drain = 1'b1;
            cmd_o.count = HOLD_CNT_W'(hcnt_q);
          end
        end
        idx_d     = INDEX_W'(1);
        saw_sep_d = 1'b0;
        wrote_d   = 1'b0;
        sel_d     = 1'b0;
        hcnt_d    = '0;
        ovf_d     = 1'b0;
      end else if (!cfg_i.field_mode) begin
        cmd_o.data = item_i.text_byte;
        if (is_cont) begin
          cmd_o.emit = sel_q;
          cmd_push_o = sel_q;
        end else begin
          saw_sep_d  = 1'b1;
          sel_d      = sel_cur;
          cmd_o.emit = sel_cur;
          cmd_push_o = sel_cur;
          idx_d      = idx_inc;
        end
      end else if (item_i.text_byte == cfg_i.delimiter) begin
        cmd_o.data = cfg_i.delimiter;
        wrote_d    = wrote_q;
        if (!saw_sep_q) begin
          saw_sep_d = 1'b1;
          if (sel_cur) begin
            cmd_o.drain = (hcnt_q != '0);
            cmd_o.count = HOLD_CNT_W'(hcnt_q);
            wrote_d     = 1'b1;
          end
          hcnt_d = '0;
        end
        idx_d = idx_inc;
        sel_d = sel_next;
        if (sel_next) begin
          cmd_o.emit = wrote_d;
          wrote_d    = 1'b1;
        end
        cmd_push_o = cmd_o.drain || cmd_o.emit;
      end else if (!saw_sep_q) begin
        if (hcnt_q < CW'(HOLD_DEPTH)) begin
          hold_wr_o.en   = 1'b1;
          hold_wr_o.addr = HOLD_CNT_W'(hcnt_q);
          hold_wr_o.data = item_i.text_byte;
          hcnt_d         = hcnt_q + CW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end else begin
        cmd_o.data = item_i.text_byte;
        cmd_o.emit = sel_q;
        cmd_push_o = sel_q;
      end
    end
  end

  always_comb begin
    pending_d = pending_q;
    if (drain_done_i) begin
      pending_d = 1'b0;
    end
    if (cmd_push_o && cmd_o.drain) begin
      pending_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= INDEX_W'(1);
      saw_sep_q <= 1'b0;
      wrote_q   <= 1'b0;
      sel_q     <= 1'b0;
      hcnt_q    <= '0;
      ovf_q     <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      saw_sep_q <= saw_sep_d;
      wrote_q   <= wrote_d;
      sel_q     <= sel_d;
      hcnt_q    <= hcnt_d;
      ovf_q     <= ovf_d;
      pending_q <= pending_d;
    end
  end

endmodule

[sv/lfcs_back.sv]
module lfcs_back
  import lfcs_pkg::*;
#(
  parameter int HOLD_DEPTH = 63,
  parameter int OUT_DEPTH  = 4,
  localparam int CW  = $clog2(HOLD_DEPTH + 1),
  localparam int AW  = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1,
  localparam int OCW = $clog2(OUT_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lfcs_hold_wr_t hold_wr_i,
  input  logic          cmd_empty_i,
  input  lfcs_cmd_t     cmd_i,
  output logic          cmd_pop_o,
  output logic          drain_done_o,
  input  logic [OCW-1:0] out_count_i,
  output logic          out_push_o,
  output lfcs_out_t     out_o
);

  logic [7:0]  store_q [HOLD_DEPTH];
  logic [7:0]  rdata_q;
  back_state_e state_q, state_d;
  logic [CW-1:0] k_q, k_d, cnt;
  logic        s1_valid_q, s1_mem_q, s1_done_q, s1_ovf_q;
  logic [7:0]  s1_byte_q;
  logic        space, issue, issue_mem;

  assign cnt   = cmd_i.count[CW-1:0];
  assign space = ({1'b0, out_count_i} + (OCW + 1)'(s1_valid_q)) < (OCW + 1)'(OUT_DEPTH);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i && space && cmd_i.drain && (cnt != '0)) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (space && (k_q == cnt)) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    k_d          = k_q;
    issue        = 1'b0;
    issue_mem    = 1'b0;
    cmd_pop_o    = 1'b0;
    drain_done_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        k_d = '0;
        if (!cmd_empty_i && space && !(cmd_i.drain && (cnt != '0))) begin
          issue     = cmd_i.emit;
          cmd_pop_o = 1'b1;
        end
      end
      BK_DRAIN: begin
        if (space) begin
          if (k_q != cnt) begin
            issue     = 1'b1;
            issue_mem = 1'b1;
            k_d       = k_q + CW'(1);
          end else begin
            issue        = cmd_i.emit;
            cmd_pop_o    = 1'b1;
            drain_done_o = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      k_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mem_q  <= issue_mem;
    s1_byte_q <= cmd_i.data;
    s1_done_q <= cmd_i.done && !issue_mem;
    s1_ovf_q  <= cmd_i.ovf;
  end

  always_ff @(posedge clk_i) begin
    if (hold_wr_i.en) begin
      store_q[hold_wr_i.addr[AW-1:0]] <= hold_wr_i.data;
    end
    if (issue_mem) begin
      rdata_q <= store_q[k_q[AW-1:0]];
    end
  end

  assign out_push_o          = s1_valid_q;
  assign out_o.out_byte      = s1_mem_q ? rdata_q : s1_byte_q;
  assign out_o.line_done     = s1_done_q;
  assign out_o.held_overflow = s1_ovf_q;

endmodule

[sv/line_field_column_selector.sv]
// a passed byte goes through the command queue, the back-end output register and the result queue
// throughput: one item per cycle while the command queue has room; a line-end or first-delimiter
//   transfer that drains n held bytes stops input until the back end has read them from the hold ram
// reset: asynchronous active low; clears the config registers to defaults, line state
//   and both queues; the hold ram is not cleared
module line_field_column_selector
  import lfcs_pkg::*;
#(
  parameter int HOLD_DEPTH = 63
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  lfcs_in_t              in_item_i,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output lfcs_out_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  lfcs_cfg_t     cfg_q;
  lfcs_cmd_t     fr_cmd, bk_cmd;
  lfcs_hold_wr_t hold_wr;
  lfcs_out_t     bk_out;
  logic          cmd_push, cmd_full, cmd_pop, cmd_empty, drain_done, out_push;
  logic [OCW-1:0] out_count;
  logic [CMD_W-1:0] cmd_rd;
  logic [OUT_W-1:0] out_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.field_mode       <= 1'b1;
      cfg_q.delimiter        <= 8'd9;
      cfg_q.complement       <= 1'b0;
      cfg_q.skip_undelimited <= 1'b0;
      cfg_q.range_a_first    <= INDEX_W'(1);
      cfg_q.range_a_final    <= INDEX_MAX;
      cfg_q.range_b_first    <= INDEX_W'(1);
      cfg_q.range_b_final    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIELD_MODE:   cfg_q.field_mode       <= cfg_data_i[0];
        CFG_DELIMITER:    cfg_q.delimiter        <= cfg_data_i[7:0];
        CFG_COMPLEMENT:   cfg_q.complement       <= cfg_data_i[0];
        CFG_SKIP_UNDELIM: cfg_q.skip_undelimited <= cfg_data_i[0];
        CFG_A_FIRST:      cfg_q.range_a_first    <= cfg_data_i;
        CFG_A_FINAL:      cfg_q.range_a_final    <= cfg_data_i;
        CFG_B_FIRST:      cfg_q.range_b_first    <= cfg_data_i;
        CFG_B_FINAL:      cfg_q.range_b_final    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lfcs_front #(.HOLD_DEPTH(HOLD_DEPTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .item_i       (in_item_i),
    .full_o       (full),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (fr_cmd),
    .hold_wr_o    (hold_wr),
    .drain_done_i (drain_done)
  );

  lfcs_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (fr_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_rd),
    .empty_o (cmd_empty),
    .count_o ()
  );

  assign bk_cmd = lfcs_cmd_t'(cmd_rd);

  lfcs_back #(.HOLD_DEPTH(HOLD_DEPTH), .OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_wr_i    (hold_wr),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (bk_cmd),
    .cmd_pop_o    (cmd_pop),
    .drain_done_o (drain_done),
    .out_count_i  (out_count),
    .out_push_o   (out_push),
    .out_o        (bk_out)
  );

  // result queue, never overrun: the back end holds off when it is near full
  lfcs_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (bk_out),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (out_rd),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_item_o = lfcs_out_t'(out_rd);

endmodule

[sv/lfcs_checker.sv]
module lfcs_checker
  import lfcs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input lfcs_out_t out_item_o
);

  // a closing result always carries the newline byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.line_done) |-> (out_item_o.out_byte == NEWLINE))
    else $error("line_done result without newline byte");

  // the result queue comes out of reset with nothing waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty)
    else $error("result waiting right after reset");

  // a waiting result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed or vanished");

endmodule

bind line_field_column_selector lfcs_checker u_lfcs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

[tb/testbench.sv]
module testbench;
  import lfcs_pkg::*;

  localparam int HOLD_DEPTH      = 63;
  localparam int QUIET_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 80;
  localparam int HOLD_OFF_CYCLES = 500;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  push       = 1'b0;
  logic                  pop        = 1'b0;
  logic                  full;
  logic                  empty;
  lfcs_in_t              in_item_i  = '0;
  lfcs_out_t             out_item_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  line_field_column_selector #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_item_i (in_item_i),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // selector state as predicted
  lfcs_cfg_t          cfg_m;
  logic [INDEX_W-1:0] idx_m;
  logic               seen_m;
  logic               wrote_m;
  logic               fsel_m;
  logic               ovf_m;
  logic [7:0]         hold_m [HOLD_DEPTH];
  int                 hold_n;

  lfcs_out_t bytes_due[$];
  lfcs_in_t  text_queue[$];
  int        staged     = 0;
  int        errors     = 0;
  int        quiet      = 0;
  logic      took_in    = 1'b0;
  int        snd_idle   = 0;
  int        rcv_idle   = 0;
  int        stall_asks = 0;
  int        stall_seen = 0;
  int        stall_left = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic logic picks(logic [INDEX_W-1:0] i);
    logic a;
    logic b;
    a = i >= cfg_m.range_a_first && i <= cfg_m.range_a_final;
    b = i >= cfg_m.range_b_first && i <= cfg_m.range_b_final;
    return (a || b) != cfg_m.complement;
  endfunction

  function automatic void emit(logic [7:0] b, logic d);
    lfcs_out_t r;
    r.out_byte      = b;
    r.line_done     = d;
    r.held_overflow = ovf_m;
    bytes_due.push_back(r);
  endfunction

  function automatic void drain_held();
    for (int k = 0; k < hold_n; k++) emit(hold_m[k], 1'b0);
  endfunction

  function automatic void fresh_line();
    idx_m   = 1;
    seen_m  = 1'b0;
    wrote_m = 1'b0;
    fsel_m  = 1'b0;
    hold_n  = 0;
    ovf_m   = 1'b0;
  endfunction

  function automatic void bump_index();
    if (idx_m != INDEX_MAX) idx_m++;
  endfunction

  function automatic void cut_predict(lfcs_in_t it);
    if (it.line_end) begin
      if (cfg_m.field_mode && !seen_m && cfg_m.skip_undelimited) begin
        fresh_line();
      end else begin
        if (cfg_m.field_mode && !seen_m) drain_held();
        emit(NEWLINE, 1'b1);
        fresh_line();
      end
    end else if (!cfg_m.field_mode) begin
      if (it.text_byte[7:6] == 2'b10 && seen_m) begin
        if (fsel_m) emit(it.text_byte, 1'b0);
      end else begin
        seen_m = 1'b1;
        fsel_m = picks(idx_m);
        if (fsel_m) emit(it.text_byte, 1'b0);
        bump_index();
      end
    end else if (it.text_byte == cfg_m.delimiter) begin
      if (!seen_m) begin
        seen_m = 1'b1;
        if (picks(idx_m)) begin
          drain_held();
          wrote_m = 1'b1;
        end
        hold_n = 0;
      end
      bump_index();
      fsel_m = picks(idx_m);
      if (fsel_m) begin
        if (wrote_m) emit(cfg_m.delimiter, 1'b0);
        wrote_m = 1'b1;
      end
    end else if (!seen_m) begin
      if (hold_n < HOLD_DEPTH) begin
        hold_m[hold_n] = it.text_byte;
        hold_n++;
      end else begin
        ovf_m = 1'b1;
      end
    end else if (fsel_m) begin
      emit(it.text_byte, 1'b0);
    end
  endfunction

  // monitor: checks result transfers, predicts from input transfers
  always @(posedge clk_i) begin : monitor
    lfcs_out_t want;
    if (rst_ni) begin
      took_in <= push && !full;
      if (pop && !empty) begin
        if (bytes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got byte %h done %b ovf %b",
                   $time, out_item_o.out_byte, out_item_o.line_done,
                   out_item_o.held_overflow);
        end else begin
          want = bytes_due.pop_front();
          if (out_item_o.out_byte !== want.out_byte ||
              out_item_o.line_done !== want.line_done ||
              out_item_o.held_overflow !== want.held_overflow) begin
            errors++;
            $display("%0t: mismatch: expected byte %h done %b ovf %b, got byte %h done %b ovf %b",
                     $time, want.out_byte, want.line_done, want.held_overflow,
                     out_item_o.out_byte, out_item_o.line_done, out_item_o.held_overflow);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FIELD_MODE:   cfg_m.field_mode       = cfg_data_i[0];
          CFG_DELIMITER:    cfg_m.delimiter        = cfg_data_i[7:0];
          CFG_COMPLEMENT:   cfg_m.complement       = cfg_data_i[0];
          CFG_SKIP_UNDELIM: cfg_m.skip_undelimited = cfg_data_i[0];
          CFG_A_FIRST:      cfg_m.range_a_first    = cfg_data_i;
          CFG_A_FINAL:      cfg_m.range_a_final    = cfg_data_i;
          CFG_B_FIRST:      cfg_m.range_b_first    = cfg_data_i;
          CFG_B_FINAL:      cfg_m.range_b_final    = cfg_data_i;
          default: ;
        endcase
      end
      if (push && !full) cut_predict(in_item_i);
    end
    if ((push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("line_field_column_selector regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // driver: offers the front of the text queue
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took_in) void'(text_queue.pop_front());
      if (!push || took_in) begin
        if (text_queue.size() > 0 && $urandom_range(99) >= snd_idle) begin
          push      <= 1'b1;
          in_item_i <= text_queue[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_asks != stall_seen) begin
        stall_seen <= stall_asks;
        stall_left <= HOLD_OFF_CYCLES;
        pop        <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        pop        <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task automatic add_byte(input logic [7:0] b);
    lfcs_in_t it;
    it.text_byte = b;
    it.line_end  = 1'b0;
    text_queue.push_back(it);
    staged++;
  endtask

  task automatic add_end();
    lfcs_in_t it;
    it.text_byte = 8'($urandom_range(255));
    it.line_end  = 1'b1;
    text_queue.push_back(it);
    staged++;
  endtask

  function automatic logic [7:0] text_pick();
    int r;
    r = $urandom_range(99);
    if (r < 18) return cfg_m.delimiter;
    if (r < 28) return 8'h80 | 8'($urandom_range(63));
    if (r < 36) return 8'hC0 | 8'($urandom_range(31));
    if (r < 40) return 8'hE0 | 8'($urandom_range(15));
    if (r < 90) return 8'h61 + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  // a held first field of the given length, then a short random tail
  task automatic add_line(input int lead_len, input bit close);
    logic [7:0] b;
    int         tail;
    tail = $urandom_range(12);
    for (int k = 0; k < lead_len; k++) begin
      b = 8'h61 + 8'($urandom_range(25));
      if (b == cfg_m.delimiter) b = 8'h41;
      add_byte(b);
    end
    for (int k = 0; k < tail; k++) add_byte(text_pick());
    if (close) add_end();
  endtask

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(4))
      0: return 8'h09;
      1: return 8'h2C;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] pick_bound(input int lo);
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return 16'(lo);
      default: return 16'($urandom_range(8, lo));
    endcase
  endfunction

  task automatic set_reg(input cfg_idx_e idx, input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic set_config(input logic fm, input logic [7:0] dl, input logic cp,
                            input logic sk, input logic [15:0] af, input logic [15:0] al,
                            input logic [15:0] bf, input logic [15:0] bl);
    logic [15:0] junk;
    junk = 16'($urandom);
    set_reg(CFG_FIELD_MODE, {junk[15:1], fm});
    set_reg(CFG_DELIMITER, {junk[15:8], dl});
    set_reg(CFG_COMPLEMENT, {junk[14:0], cp});
    set_reg(CFG_SKIP_UNDELIM, {junk[13:0], junk[15], sk});
    set_reg(CFG_A_FIRST, af);
    set_reg(CFG_A_FINAL, al);
    set_reg(CFG_B_FIRST, bf);
    set_reg(CFG_B_FINAL, bl);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (text_queue.size() != 0 || push || bytes_due.size() != 0 || stall_left != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int target;
    bit first;
    cfg_m.field_mode       = 1'b1;
    cfg_m.delimiter        = 8'h09;
    cfg_m.complement       = 1'b0;
    cfg_m.skip_undelimited = 1'b0;
    cfg_m.range_a_first    = 16'd1;
    cfg_m.range_a_final    = 16'hFFFF;
    cfg_m.range_b_first    = 16'd1;
    cfg_m.range_b_final    = 16'd0;
    fresh_line();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty field, undelimited line, byte extremes, empty line
    add_byte(8'h61); add_byte(8'h09); add_byte(8'h09); add_byte(8'h62); add_byte(8'h63);
    add_end();
    add_byte(8'h78); add_byte(8'h79); add_byte(8'h7A); add_end();
    add_byte(8'h00); add_byte(8'hFF); add_end();
    add_end();
    wait_idle();

    // skipped line, then field two on a 0xff delimiter
    set_config(1'b1, 8'hFF, 1'b0, 1'b1, 16'd2, 16'd2, 16'hFFFF, 16'hFFFF);
    add_byte(8'h6E); add_byte(8'h6F); add_end();
    add_byte(8'h41); add_byte(8'hFF); add_byte(8'h42); add_byte(8'hFF); add_byte(8'h43);
    add_end();
    wait_idle();

    // characters: leading continuation, two- and three-byte sequences
    set_config(1'b0, 8'h09, 1'b0, 1'b0, 16'd1, 16'd2, 16'd4, 16'hFFFF);
    add_byte(8'h80); add_byte(8'hC3); add_byte(8'hA9); add_byte(8'h78);
    add_byte(8'hE2); add_byte(8'h82); add_byte(8'hAC); add_end();
    wait_idle();

    // long receiver hold-off with the sender busy
    set_config(1'b0, 8'h09, 1'b0, 1'b0, 16'd1, 16'hFFFF, 16'd1, 16'd0);
    @(posedge clk_i);
    stall_asks++;
    for (int k = 0; k < 40; k++) begin
      if (k % 20 == 19) add_end();
      else add_byte(text_pick());
    end
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin snd_idle = 0;  rcv_idle = 0;  end
        1: begin snd_idle = 56; rcv_idle = 0;  end
        2: begin snd_idle = 0;  rcv_idle = 56; end
        default: begin snd_idle = 37; rcv_idle = 37; end
      endcase
      if (p == 0)
        set_config(1'b1, 8'h2C, 1'b0, 1'b0, 16'd1, 16'd1, 16'd3, 16'd4);
      else
        set_config(1'($urandom_range(1)), pick_delim(), 1'($urandom_range(1)),
                   1'($urandom_range(1)), pick_bound(1), pick_bound(0),
                   pick_bound(1), pick_bound(0));
      target = staged + 20;
      first  = (p == 0);
      while (staged < target) begin
        add_line((first || $urandom_range(15) == 0) ? $urandom_range(70, 60) : 0,
                 $urandom_range(9) != 0);
        first = 1'b0;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("line_field_column_selector regression: pass");
    end else begin
      $display("line_field_column_selector regression: fail");
    end
    $finish;
  end

endmodule
